>>> src/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and idle in reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PPS_ASSERT_IMP(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define PPS_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> src/pps_pkg.sv
// -----------------------------------------------------------------------------
// Phong point light shader package
// Register indexes, reset values, fixed-point constants and stage payload types.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_POS_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_POS_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_POS_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_RGB     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AMBIENT_GAIN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFFUSE_GAIN  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPECULAR_GAIN = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SHININESS     = 3'd7;

   localparam logic [15:0] AMBIENT_GAIN_RST  = 16'd1638;
   localparam logic [15:0] DIFFUSE_GAIN_RST  = 16'd14746;
   localparam logic [15:0] SPECULAR_GAIN_RST = 16'd14746;
   localparam logic [9:0]  SHININESS_RST     = 10'd200;

   // 1.0 in Q.28
   localparam logic [28:0] ONE_Q28 = 29'h1000_0000;

   localparam int SQRT_STEPS = 31;  // root bits of a 62-bit radicand
   localparam int DIV_STEPS  = 15;  // quotient bits, result <= 1.0 in Q2.14
   localparam int POW_BITS   = 10;  // exponent width

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [15:0] eye_x;
      logic signed [15:0] eye_y;
      logic signed [15:0] eye_z;
      logic [47:0]        surface_rgb;
      logic               in_shadow;
   } geo_type;

   typedef struct packed {
      logic [47:0] surface_rgb;
      logic        lit;
      logic        spec;
      logic [28:0] cos_d;
   } shade_type;

endpackage

`default_nettype wire

>>> src/pps_light_dir.sv
// -----------------------------------------------------------------------------
// Light direction unit
// Normalizes light - point to a Q2.14 unit vector: magnitude, range scaling,
// sum of squares, one root bit per stage, one quotient bit per stage.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pps_light_dir (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic signed [32:0]    dir_x,
   input  logic signed [32:0]    dir_y,
   input  logic signed [32:0]    dir_z,
   input  pps_pkg::geo_type      in_geo,
   output logic                  out_valid,
   output logic signed [15:0]    lv_x,
   output logic signed [15:0]    lv_y,
   output logic signed [15:0]    lv_z,
   output pps_pkg::geo_type      out_geo
);
   import pps_pkg::*;

   localparam int FRONT = 6;
   localparam int NSTG  = FRONT + SQRT_STEPS + DIV_STEPS + 1;

   typedef struct packed {
      logic [2:0] neg;
      logic       zero;
      geo_type    geo;
   } meta_type;

   typedef struct packed {
      logic [32:0]      rem;
      logic [30:0]      root;
      logic [61:0]      rad;
      logic [2:0][29:0] norm;
      meta_type         meta;
   } sq_type;

   typedef struct packed {
      logic [2:0][31:0] rem;
      logic [2:0][14:0] quo;
      logic [30:0]      len;
      meta_type         meta;
   } dv_type;

   logic [NSTG-1:0] vld_ff;

   logic signed [32:0] dir [3];
   logic [2:0][32:0]   a_mag_ff;
   meta_type           a_meta_ff;
   logic [2:0][32:0]   b_mag_ff;
   logic [32:0]        b_max_ff;
   meta_type           b_meta_ff;
   logic [5:0]         msb;
   logic [2:0][32:0]   c_mag_ff;
   logic               c_right_ff;
   logic [4:0]         c_amt_ff;
   meta_type           c_meta_ff;
   logic [2:0][29:0]   d_norm_ff;
   meta_type           d_meta_ff;
   logic [2:0][59:0]   e_sqr_ff;
   logic [2:0][29:0]   e_norm_ff;
   meta_type           e_meta_ff;
   logic [61:0]        f_sum_ff;
   logic [2:0][29:0]   f_norm_ff;
   meta_type           f_meta_ff;

   sq_type sq_first;
   sq_type sq_ff [SQRT_STEPS];
   dv_type dv_first;
   dv_type dv_ff [DIV_STEPS];

   logic signed [15:0] lv_ff [3];
   geo_type            out_geo_ff;

   assign dir[0] = dir_x;
   assign dir[1] = dir_y;
   assign dir[2] = dir_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_valid};
      end
   end

   // magnitudes
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            a_mag_ff[i]      <= dir[i][32] ? 33'(-dir[i]) : 33'(dir[i]);
            a_meta_ff.neg[i] <= dir[i][32];
         end
         a_meta_ff.zero <= 1'b0;
         a_meta_ff.geo  <= in_geo;
      end
   end

   // largest magnitude
   always_ff @(posedge clock) begin
      if (en) begin
         b_mag_ff  <= a_mag_ff;
         b_meta_ff <= a_meta_ff;
         if (a_mag_ff[0] >= a_mag_ff[1] && a_mag_ff[0] >= a_mag_ff[2]) begin
            b_max_ff <= a_mag_ff[0];
         end else if (a_mag_ff[1] >= a_mag_ff[2]) begin
            b_max_ff <= a_mag_ff[1];
         end else begin
            b_max_ff <= a_mag_ff[2];
         end
      end
   end

   // leading one of the max, scale so it lands on bit 29
   always_comb begin
      msb = '0;
      for (int i = 0; i < 33; i++) begin
         if (b_max_ff[i]) msb = 6'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_mag_ff       <= b_mag_ff;
         c_meta_ff      <= b_meta_ff;
         c_meta_ff.zero <= (b_max_ff == '0);
         c_right_ff     <= (msb > 6'd29);
         c_amt_ff       <= (msb > 6'd29) ? 5'(msb - 6'd29) : 5'(6'd29 - msb);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            d_norm_ff[i] <= c_right_ff ? 30'(c_mag_ff[i] >> c_amt_ff)
                                       : 30'(c_mag_ff[i] << c_amt_ff);
         end
         d_meta_ff <= c_meta_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            e_sqr_ff[i] <= 60'(d_norm_ff[i]) * 60'(d_norm_ff[i]);
         end
         e_norm_ff <= d_norm_ff;
         e_meta_ff <= d_meta_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_sum_ff  <= 62'(e_sqr_ff[0]) + 62'(e_sqr_ff[1]) + 62'(e_sqr_ff[2]);
         f_norm_ff <= e_norm_ff;
         f_meta_ff <= e_meta_ff;
      end
   end

   // square root, one root bit per stage
   always_comb begin
      sq_first      = '0;
      sq_first.rad  = f_sum_ff;
      sq_first.norm = f_norm_ff;
      sq_first.meta = f_meta_ff;
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      sq_type     src;
      sq_type     step_in;
      logic [34:0] rem_t;
      logic [34:0] trial;

      if (k == 0) begin : g_first
         assign src = sq_first;
      end else begin : g_rest
         assign src = sq_ff[k-1];
      end

      always_comb begin
         step_in     = src;
         rem_t       = {src.rem, src.rad[61:60]};
         trial       = {2'b00, src.root, 2'b01};
         step_in.rad = {src.rad[59:0], 2'b00};
         if (rem_t >= trial) begin
            step_in.rem  = 33'(rem_t - trial);
            step_in.root = {src.root[29:0], 1'b1};
         end else begin
            step_in.rem  = rem_t[32:0];
            step_in.root = {src.root[29:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) sq_ff[k] <= step_in;
      end
   end

   // (norm << 14) / len, one quotient bit per stage, three lanes
   always_comb begin
      dv_first = '0;
      for (int i = 0; i < 3; i++) begin
         dv_first.rem[i] = 32'(sq_ff[SQRT_STEPS-1].norm[i]);
      end
      dv_first.len  = sq_ff[SQRT_STEPS-1].root;
      dv_first.meta = sq_ff[SQRT_STEPS-1].meta;
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      dv_type      src;
      dv_type      step_in;
      logic [31:0] t [3];

      if (j == 0) begin : g_first
         assign src = dv_first;
      end else begin : g_rest
         assign src = dv_ff[j-1];
      end

      always_comb begin
         step_in = src;
         for (int i = 0; i < 3; i++) begin
            t[i] = (j == 0) ? src.rem[i] : {src.rem[i][30:0], 1'b0};
            if (t[i] >= 32'(src.len)) begin
               step_in.rem[i] = t[i] - 32'(src.len);
               step_in.quo[i] = {src.quo[i][13:0], 1'b1};
            end else begin
               step_in.rem[i] = t[i];
               step_in.quo[i] = {src.quo[i][13:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) dv_ff[j] <= step_in;
      end
   end

   // restore signs; a light sitting on the point gives the zero vector
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            if (dv_ff[DIV_STEPS-1].meta.zero) begin
               lv_ff[i] <= '0;
            end else if (dv_ff[DIV_STEPS-1].meta.neg[i]) begin
               lv_ff[i] <= -signed'({1'b0, dv_ff[DIV_STEPS-1].quo[i]});
            end else begin
               lv_ff[i] <= signed'({1'b0, dv_ff[DIV_STEPS-1].quo[i]});
            end
         end
         out_geo_ff <= dv_ff[DIV_STEPS-1].meta.geo;
      end
   end

   assign out_valid = vld_ff[NSTG-1];
   assign lv_x      = lv_ff[0];
   assign lv_y      = lv_ff[1];
   assign lv_z      = lv_ff[2];
   assign out_geo   = out_geo_ff;

   `PPS_ASSERT_IMP(a_lv_unit, out_valid,
      lv_x <= 16'sd16384 && lv_x >= -16'sd16384 && lv_y <= 16'sd16384 &&
      lv_y >= -16'sd16384 && lv_z <= 16'sd16384 && lv_z >= -16'sd16384,
      "light vector component beyond 1.0")

endmodule

`default_nettype wire

>>> src/pps_power.sv
// -----------------------------------------------------------------------------
// Specular power unit
// c^n in Q.28 by square and multiply, exponent MSB first, one product per stage.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pps_power (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [28:0]         cos_s,
   input  logic [9:0]          exponent,
   input  pps_pkg::shade_type  in_shade,
   output logic                out_valid,
   output logic [28:0]         factor,
   output pps_pkg::shade_type  out_shade
);
   import pps_pkg::*;

   localparam int NSTG = 2 * POW_BITS;

   typedef struct packed {
      logic [28:0] acc;
      logic [28:0] base;
      shade_type   shade;
   } pw_type;

   logic [NSTG-1:0] vld_ff;
   pw_type          pw_ff [NSTG];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_valid};
      end
   end

   // even stages square, odd stages multiply by c when the exponent bit is set
   for (genvar k = 0; k < NSTG; k++) begin : g_step
      localparam int EBIT   = POW_BITS - 1 - k / 2;
      localparam bit SQUARE = (k % 2) == 0;
      pw_type      src;
      pw_type      step_in;
      logic [57:0] prod;

      if (k == 0) begin : g_first
         assign src = '{acc: ONE_Q28, base: cos_s, shade: in_shade};
      end else begin : g_rest
         assign src = pw_ff[k-1];
      end

      always_comb begin
         step_in = src;
         prod    = 58'(src.acc) * 58'(SQUARE ? src.acc : src.base);
         if (SQUARE || exponent[EBIT]) step_in.acc = prod[56:28];
      end

      always_ff @(posedge clock) begin
         if (en) pw_ff[k] <= step_in;
      end
   end

   assign out_valid = vld_ff[NSTG-1];
   assign factor    = pw_ff[NSTG-1].acc;
   assign out_shade = pw_ff[NSTG-1].shade;

   `PPS_ASSERT_IMP(a_factor_max, out_valid, factor <= ONE_Q28,
      "specular factor above 1.0")

endmodule

`default_nettype wire

>>> src/phong_point_light_shader_top.sv
// -----------------------------------------------------------------------------
// Phong point light shader
// Ambient, diffuse and specular shading of one surface hit per transaction.
// -----------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    point, eye, normal, surface_rgb, shadow
//   rsp      out        rsp_valid/ready    out_red, out_green, out_blue
//   csr      in         csr_write_en       csr_index, csr_wdata (no read-back)
//
// One transaction enters per cycle while the pipeline advances; the path runs
// through the 31-stage square root and 15-stage divider of the light direction
// and the 20 products of the specular power.
// The whole pipeline advances when the result register is empty or taken, so
// a stall holds every stage in place; req_ready is that same advance enable.
// Reset is synchronous: it clears valid bits and loads register defaults.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module phong_point_light_shader_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [31:0]               req_point_x,
   input  logic signed [31:0]               req_point_y,
   input  logic signed [31:0]               req_point_z,
   input  logic signed [15:0]               req_eye_x,
   input  logic signed [15:0]               req_eye_y,
   input  logic signed [15:0]               req_eye_z,
   input  logic signed [15:0]               req_normal_x,
   input  logic signed [15:0]               req_normal_y,
   input  logic signed [15:0]               req_normal_z,
   input  logic [47:0]                      req_surface_rgb,
   input  logic                             req_in_shadow,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [15:0]                      rsp_out_red,
   output logic [15:0]                      rsp_out_green,
   output logic [15:0]                      rsp_out_blue,
   input  logic                             csr_write_en,
   input  logic [pps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pps_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pps_pkg::*;

   // configuration
   logic signed [31:0] light_x_ff, light_y_ff, light_z_ff;
   logic [47:0]        light_rgb_ff;
   logic [15:0]        ambient_gain_ff, diffuse_gain_ff, specular_gain_ff;
   logic [9:0]         shininess_ff;

   logic en;

   // front stage: light - point
   logic               t1_valid_ff;
   logic signed [32:0] t1_dx_ff, t1_dy_ff, t1_dz_ff;
   geo_type            t1_geo_ff;

   // light direction unit outputs
   logic               ld_valid;
   logic signed [15:0] ld_lv [3];
   geo_type            ld_geo;

   // dot products and reflection
   logic [6:0]         pv_ff;
   logic signed [15:0] ld_nv [3];
   logic signed [31:0] p1_prod_ff [3];
   logic signed [15:0] p1_lv_ff [3];
   geo_type            p1_geo_ff;
   logic signed [33:0] p2_ldn_ff;
   logic signed [15:0] p2_lv_ff [3];
   geo_type            p2_geo_ff;
   logic signed [15:0] p2_nv [3];
   logic signed [49:0] p3_m_ff [3];
   logic signed [15:0] p3_lv_ff [3];
   geo_type            p3_geo_ff;
   logic               p3_lit_ff;
   logic [28:0]        p3_cd_ff;
   logic signed [51:0] p4_r42_ff [3];
   geo_type            p4_geo_ff;
   logic               p4_lit_ff;
   logic [28:0]        p4_cd_ff;
   logic signed [51:0] p5_adj [3];
   logic signed [23:0] p5_rv_ff [3];
   geo_type            p5_geo_ff;
   logic               p5_lit_ff;
   logic [28:0]        p5_cd_ff;
   logic signed [15:0] p5_ev [3];
   logic signed [39:0] p6_pe_ff [3];
   geo_type            p6_geo_ff;
   logic               p6_lit_ff;
   logic [28:0]        p6_cd_ff;
   logic signed [41:0] p7_rde;
   logic               p7_spec_in;
   logic [28:0]        p7_cs_in;
   logic [28:0]        p7_cs_ff;
   shade_type          p7_shade_ff;

   // power unit outputs
   logic               pw_valid;
   logic [28:0]        pw_factor;
   shade_type          pw_shade;

   // color stages
   logic [3:0]         cv_ff;
   logic [31:0]        c1_eff_ff [3];
   logic [31:0]        c1_ls_ff [3];
   logic [28:0]        c1_factor_ff;
   shade_type          c1_shade_ff;
   logic [33:0]        c2_amb_in [3];
   logic [33:0]        c2_ed_in [3];
   logic [30:0]        c2_sp_in [3];
   logic [33:0]        c2_amb_ff [3];
   logic [33:0]        c2_ed_ff [3];
   logic [30:0]        c2_sp_ff [3];
   shade_type          c2_shade_ff;
   logic [34:0]        c3_dif_in [3];
   logic [33:0]        c3_amb_ff [3];
   logic [34:0]        c3_dif_ff [3];
   logic [30:0]        c3_sp_ff [3];
   logic               c3_lit_ff;
   logic               c3_spec_ff;
   logic [35:0]        c4_total [3];
   logic [15:0]        out_ff [3];

   // ---------------------------------------------------------------------------
   // Register file: user rule, unchecked: written only while no transaction is in flight
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff       <= '0;
         light_y_ff       <= '0;
         light_z_ff       <= '0;
         light_rgb_ff     <= '0;
         ambient_gain_ff  <= AMBIENT_GAIN_RST;
         diffuse_gain_ff  <= DIFFUSE_GAIN_RST;
         specular_gain_ff <= SPECULAR_GAIN_RST;
         shininess_ff     <= SHININESS_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_LIGHT_POS_X:   light_x_ff       <= signed'(csr_wdata[31:0]);
            CSR_LIGHT_POS_Y:   light_y_ff       <= signed'(csr_wdata[31:0]);
            CSR_LIGHT_POS_Z:   light_z_ff       <= signed'(csr_wdata[31:0]);
            CSR_LIGHT_RGB:     light_rgb_ff     <= csr_wdata[47:0];
            CSR_AMBIENT_GAIN:  ambient_gain_ff  <= csr_wdata[15:0];
            CSR_DIFFUSE_GAIN:  diffuse_gain_ff  <= csr_wdata[15:0];
            CSR_SPECULAR_GAIN: specular_gain_ff <= csr_wdata[15:0];
            CSR_SHININESS:     shininess_ff     <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Flow control: one global advance enable
   // ---------------------------------------------------------------------------
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // ---------------------------------------------------------------------------
   // Stage T1: light direction, 33-bit so no wrap
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
      end else if (en) begin
         t1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_dx_ff              <= 33'(light_x_ff) - 33'(req_point_x);
         t1_dy_ff              <= 33'(light_y_ff) - 33'(req_point_y);
         t1_dz_ff              <= 33'(light_z_ff) - 33'(req_point_z);
         t1_geo_ff.normal_x    <= req_normal_x;
         t1_geo_ff.normal_y    <= req_normal_y;
         t1_geo_ff.normal_z    <= req_normal_z;
         t1_geo_ff.eye_x       <= req_eye_x;
         t1_geo_ff.eye_y       <= req_eye_y;
         t1_geo_ff.eye_z       <= req_eye_z;
         t1_geo_ff.surface_rgb <= req_surface_rgb;
         t1_geo_ff.in_shadow   <= req_in_shadow;
      end
   end

   pps_light_dir u_light_dir (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (t1_valid_ff),
      .dir_x     (t1_dx_ff),
      .dir_y     (t1_dy_ff),
      .dir_z     (t1_dz_ff),
      .in_geo    (t1_geo_ff),
      .out_valid (ld_valid),
      .lv_x      (ld_lv[0]),
      .lv_y      (ld_lv[1]),
      .lv_z      (ld_lv[2]),
      .out_geo   (ld_geo)
   );

   // ---------------------------------------------------------------------------
   // Stages P1..P7: L.N, reflection R = 2(L.N)N - L, R.E
   // ---------------------------------------------------------------------------
   assign ld_nv[0] = ld_geo.normal_x;
   assign ld_nv[1] = ld_geo.normal_y;
   assign ld_nv[2] = ld_geo.normal_z;
   assign p2_nv[0] = p2_geo_ff.normal_x;
   assign p2_nv[1] = p2_geo_ff.normal_y;
   assign p2_nv[2] = p2_geo_ff.normal_z;
   assign p5_ev[0] = p5_geo_ff.eye_x;
   assign p5_ev[1] = p5_geo_ff.eye_y;
   assign p5_ev[2] = p5_geo_ff.eye_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else if (en) begin
         pv_ff <= {pv_ff[5:0], ld_valid};
      end
   end

   // truncating divide by 2^28: bias negatives before the arithmetic shift
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p5_adj[i] = p4_r42_ff[i] + (p4_r42_ff[i][51] ? 52'sd268435455 : 52'sd0);
      end
   end

   // R.E sum; specular only when lit and the reflection meets the eye
   always_comb begin
      p7_rde     = 42'(p6_pe_ff[0]) + 42'(p6_pe_ff[1]) + 42'(p6_pe_ff[2]);
      p7_spec_in = p6_lit_ff && (p7_rde > 42'sd0);
      if (!p7_spec_in) begin
         p7_cs_in = '0;
      end else if (p7_rde > 42'sd268435456) begin
         p7_cs_in = ONE_Q28;
      end else begin
         p7_cs_in = p7_rde[28:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            p1_prod_ff[i] <= ld_lv[i] * ld_nv[i];
            p1_lv_ff[i]   <= ld_lv[i];
            p2_lv_ff[i]   <= p1_lv_ff[i];
            p3_m_ff[i]    <= p2_ldn_ff * p2_nv[i];
            p3_lv_ff[i]   <= p2_lv_ff[i];
            p4_r42_ff[i]  <= (52'(p3_m_ff[i]) <<< 1) - (52'(p3_lv_ff[i]) <<< 28);
            p5_rv_ff[i]   <= 24'(p5_adj[i] >>> 28);
            p6_pe_ff[i]   <= p5_rv_ff[i] * p5_ev[i];
         end
         p1_geo_ff <= ld_geo;
         p2_ldn_ff <= 34'(p1_prod_ff[0]) + 34'(p1_prod_ff[1]) + 34'(p1_prod_ff[2]);
         p2_geo_ff <= p1_geo_ff;
         p3_geo_ff <= p2_geo_ff;
         p3_lit_ff <= !p2_geo_ff.in_shadow && !p2_ldn_ff[33];
         if (p2_geo_ff.in_shadow || p2_ldn_ff[33]) begin
            p3_cd_ff <= '0;
         end else if (p2_ldn_ff > 34'sd268435456) begin
            p3_cd_ff <= ONE_Q28;
         end else begin
            p3_cd_ff <= p2_ldn_ff[28:0];
         end
         p4_geo_ff <= p3_geo_ff;
         p4_lit_ff <= p3_lit_ff;
         p4_cd_ff  <= p3_cd_ff;
         p5_geo_ff <= p4_geo_ff;
         p5_lit_ff <= p4_lit_ff;
         p5_cd_ff  <= p4_cd_ff;
         p6_geo_ff <= p5_geo_ff;
         p6_lit_ff <= p5_lit_ff;
         p6_cd_ff  <= p5_cd_ff;
         p7_cs_ff                <= p7_cs_in;
         p7_shade_ff.surface_rgb <= p6_geo_ff.surface_rgb;
         p7_shade_ff.lit         <= p6_lit_ff;
         p7_shade_ff.spec        <= p7_spec_in;
         p7_shade_ff.cos_d       <= p6_cd_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Specular power c^shininess
   // ---------------------------------------------------------------------------
   pps_power u_power (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pv_ff[6]),
      .cos_s     (p7_cs_ff),
      .exponent  (shininess_ff),
      .in_shade  (p7_shade_ff),
      .out_valid (pw_valid),
      .factor    (pw_factor),
      .out_shade (pw_shade)
   );

   // ---------------------------------------------------------------------------
   // Stages C1..C4: per-channel color, sum, saturate
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= '0;
      end else if (en) begin
         cv_ff <= {cv_ff[2:0], pw_valid};
      end
   end

   always_comb begin
      logic [47:0] pa;
      logic [47:0] pd;
      logic [60:0] ps;
      logic [62:0] pf;
      for (int i = 0; i < 3; i++) begin
         pa           = 48'(c1_eff_ff[i]) * 48'(ambient_gain_ff);
         pd           = 48'(c1_eff_ff[i]) * 48'(diffuse_gain_ff);
         ps           = 61'(c1_ls_ff[i]) * 61'(c1_factor_ff);
         c2_amb_in[i] = pa[47:14];
         c2_ed_in[i]  = pd[47:14];
         c2_sp_in[i]  = ps[60:30];
         pf           = 63'(c2_ed_ff[i]) * 63'(c2_shade_ff.cos_d);
         c3_dif_in[i] = pf[62:28];
         c4_total[i]  = 36'(c3_amb_ff[i])
                      + (c3_lit_ff  ? 36'(c3_dif_ff[i]) : 36'd0)
                      + (c3_spec_ff ? 36'(c3_sp_ff[i])  : 36'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            // effective color and light times specular gain
            c1_eff_ff[i] <= 32'(pw_shade.surface_rgb[47 - 16*i -: 16])
                          * 32'(light_rgb_ff[47 - 16*i -: 16]);
            c1_ls_ff[i]  <= 32'(light_rgb_ff[47 - 16*i -: 16]) * 32'(specular_gain_ff);
            c2_amb_ff[i] <= c2_amb_in[i];
            c2_ed_ff[i]  <= c2_ed_in[i];
            c2_sp_ff[i]  <= c2_sp_in[i];
            c3_amb_ff[i] <= c2_amb_ff[i];
            c3_dif_ff[i] <= c3_dif_in[i];
            c3_sp_ff[i]  <= c2_sp_ff[i];
            out_ff[i]    <= (|c4_total[i][35:28]) ? 16'hFFFF : c4_total[i][27:12];
         end
         c1_factor_ff <= pw_factor;
         c1_shade_ff  <= pw_shade;
         c2_shade_ff  <= c1_shade_ff;
         c3_lit_ff    <= c2_shade_ff.lit;
         c3_spec_ff   <= c2_shade_ff.spec;
      end
   end

   assign rsp_valid     = cv_ff[3];
   assign rsp_out_red   = out_ff[0];
   assign rsp_out_green = out_ff[1];
   assign rsp_out_blue  = out_ff[2];

   `PPS_ASSERT_IMP(a_shadow_ambient, pv_ff[2] && p3_geo_ff.in_shadow,
      !p3_lit_ff && (p3_cd_ff == '0), "shadowed hit marked as lit")
   `PPS_ASSERT_IMP(a_spec_needs_lit, cv_ff[0], !c1_shade_ff.spec || c1_shade_ff.lit,
      "specular flagged on an unlit hit")
   `PPS_ASSERT_NEXT(a_final_advance, en && cv_ff[2], rsp_valid,
      "result lost in the final stage")

endmodule

`default_nettype wire
